// ===== hdl/pmf_pkg.sv =====
`default_nettype none
package pmf_pkg;
  localparam int CHANNELS = 2;
  localparam int BLOCKS_PER_CHANNEL = 8;
  localparam int PAGES_PER_BLK = 4;
  localparam int LBA_COUNT = 32;
  localparam int BLOCK_COUNT = CHANNELS * BLOCKS_PER_CHANNEL;
  localparam int TOTAL_PAGES = BLOCK_COUNT * PAGES_PER_BLK;
  localparam int CW = $clog2(CHANNELS);
  localparam int BW = $clog2(BLOCKS_PER_CHANNEL);
  localparam int PW = $clog2(PAGES_PER_BLK);
  localparam int LW = $clog2(LBA_COUNT);
  localparam int MAPW = 1 + CW + BW + PW;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_COLLECT = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_UNMAPPED = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_MOVED = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;
  localparam logic [2:0] ST_NO_VICTIM = 3'd5;
  localparam logic [2:0] ST_LOST = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_WR_RD, S_WR_OLD, S_WR_ALLOC, S_RD_OUT, S_SCAN, S_SCAN_LAST,
    S_PG_RD, S_PG_CHK, S_MOVE, S_ERASE, S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] item_lba;
    logic       out_channel;
    logic [2:0] block;
    logic [1:0] page;
    logic [2:0] from_block;
    logic [1:0] from_page;
    logic [3:0] free_blocks;
    logic       needs_collect;
    logic       last;
  } result_t;
endpackage
`default_nettype wire

// ===== hdl/page_map_ftl_greedy_gc.sv =====
// Page-mapped flash translation block with greedy garbage collection.
// Input channel: in_valid/in_stall with kind, lba, channel. Output channel:
// out_valid/out_stall with one result word per field port; last marks the
// final word of an item. One item is worked at a time.
// Steps per item: a write is accept, map read, old page clear, allocate and
// result. A collect is accept, a scan over the channel's blocks and a decision,
// then an owner read and check per victim page, a move and result word per
// moved page, and the erase and its word; with no victim it ends at the decision.
// Each result word waits in the output register until taken; a stalled
// output holds the sequencer.
// The LBA map lives in a registered-read RAM, as does the page owner table;
// per-block page valid masks, block counts and rings are flip-flop tables.
// Reset (rst, synchronous) clears the map through valid bits, so no clearing
// pass is needed: the block accepts an item the cycle after reset.
// User writes gc_threshold via cfg_we/cfg_data when idle, unchecked; reset value 2.
`default_nettype none
module page_map_ftl_greedy_gc
  import pmf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] kind,
  input  wire logic [4:0] lba,
  input  wire logic       channel,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      status,
  output logic [4:0]      item_lba,
  output logic            out_channel,
  output logic [2:0]      block,
  output logic [1:0]      page,
  output logic [2:0]      from_block,
  output logic [1:0]      from_page,
  output logic [3:0]      free_blocks,
  output logic            needs_collect,
  output logic            last
);
  localparam int BIW = $clog2(BLOCK_COUNT);
  localparam int PIW = $clog2(TOTAL_PAGES);

  state_t state, state_next, ret;
  logic [3:0] gc_threshold;
  logic [PAGES_PER_BLK-1:0] page_valid [BLOCK_COUNT];
  logic [LBA_COUNT-1:0] map_mapped;
  logic [PW:0] bcount [BLOCK_COUNT];
  logic [BLOCK_COUNT-1:0] erased;
  logic [BW-1:0] ring [BLOCK_COUNT];
  logic [BW-1:0] head [CHANNELS];
  logic [BW-1:0] tail [CHANNELS];
  logic [BW:0] fcount [CHANNELS];
  logic [CHANNELS-1:0] open_v;
  logic [BW-1:0] open_blk [CHANNELS];
  logic [PW:0] open_pg [CHANNELS];

  logic [LW-1:0] cur_lba;
  logic [CW-1:0] ch;
  logic [BW-1:0] idx, victim;
  logic found;
  logic [PW:0] minv;
  logic [PW-1:0] pidx;
  result_t res, pend;

  // map RAM: {ch, blk, pg}
  logic map_we;
  logic [LW-1:0] map_waddr, map_raddr;
  logic [CW+BW+PW-1:0] map_wdata, map_rdata;
  pmf_ram #(.WIDTH(CW+BW+PW), .DEPTH(LBA_COUNT)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata));

  logic own_we;
  logic [PIW-1:0] own_waddr, own_raddr;
  logic [LW-1:0] own_wdata, own_rdata;
  pmf_ram #(.WIDTH(LW), .DEPTH(TOTAL_PAGES)) u_own (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .raddr(own_raddr), .rdata(own_rdata));

  logic [CW-1:0] m_ch;
  logic [BW-1:0] m_blk;
  logic [PW-1:0] m_pg;
  assign {m_ch, m_blk, m_pg} = map_rdata;

  logic [BIW-1:0] scan_bi, vic_bi;
  logic [PIW-1:0] vic_pi;
  assign scan_bi = {ch, idx};
  assign vic_bi = {ch, victim};
  assign vic_pi = {ch, victim, pidx};
  assign map_raddr = (state == S_IDLE) ? lba[LW-1:0] : cur_lba;
  assign own_raddr = vic_pi;

  // allocation view for channel ch
  logic need_open, can_alloc;
  logic [BW-1:0] pop_blk, alloc_blk;
  logic [PW-1:0] alloc_pg;
  logic [PAGES_PER_BLK-1:0] alloc_bit;
  assign need_open = !open_v[ch] || open_pg[ch] >= (PW+1)'(PAGES_PER_BLK);
  assign pop_blk = ring[{ch, head[ch]}];
  assign can_alloc = !need_open || fcount[ch] != '0;
  assign alloc_blk = need_open ? pop_blk : open_blk[ch];
  assign alloc_pg = need_open ? '0 : open_pg[ch][PW-1:0];
  assign alloc_bit = PAGES_PER_BLK'(1) << alloc_pg;

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) begin
        unique case (kind)
          KIND_WRITE: state_next = S_WR_RD;
          KIND_READ: state_next = S_RD_OUT;
          KIND_COLLECT: state_next = S_SCAN;
          default: state_next = S_IDLE;
        endcase
      end
      S_WR_RD: state_next = S_WR_OLD;
      S_WR_OLD: state_next = S_WR_ALLOC;
      S_WR_ALLOC: state_next = S_OUT;
      S_RD_OUT: state_next = S_OUT;
      S_SCAN: if (idx == BW'(BLOCKS_PER_CHANNEL-1)) state_next = S_SCAN_LAST;
      S_SCAN_LAST: state_next = found ? S_PG_RD : S_OUT;
      S_PG_RD: state_next = S_PG_CHK;
      S_PG_CHK: begin
        if (page_valid[vic_bi][pidx]) state_next = S_MOVE;
        else if (pidx == PW'(PAGES_PER_BLK-1)) state_next = S_ERASE;
        else state_next = S_PG_RD;
      end
      S_MOVE: if (out_free) state_next = S_OUT;
      S_ERASE: state_next = S_OUT;
      S_OUT: if (out_free) state_next = ret;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    map_we = 1'b0;
    map_waddr = cur_lba;
    map_wdata = {ch, alloc_blk, alloc_pg};
    own_we = 1'b0;
    own_waddr = {ch, alloc_blk, alloc_pg};
    own_wdata = cur_lba;
    if ((state == S_WR_ALLOC || state == S_MOVE && out_free) && can_alloc) begin
      map_we = 1'b1;
      own_we = 1'b1;
      if (state == S_MOVE) begin
        map_waddr = own_rdata;
        own_wdata = own_rdata;
      end
    end
  end

  function automatic result_t mk(input logic [2:0] st, input logic [LW-1:0] l,
      input logic [CW-1:0] c, input logic [BW-1:0] b, input logic [PW-1:0] p,
      input logic [BW-1:0] fb, input logic [PW-1:0] fp, input logic [BW:0] fc,
      input logic [3:0] th, input logic ls);
    result_t r;
    r.status = st;
    r.item_lba = 5'(l);
    r.out_channel = 1'(c);
    r.block = 3'(b);
    r.page = 2'(p);
    r.from_block = 3'(fb);
    r.from_page = 2'(fp);
    r.free_blocks = 4'(fc);
    r.needs_collect = 4'(fc) < th;
    r.last = ls;
    return r;
  endfunction

  logic [BW:0] fc_after;
  assign fc_after = (need_open && can_alloc) ? fcount[ch] - 1'b1 : fcount[ch];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      gc_threshold <= 4'd2;
      map_mapped <= '0;
      erased <= '1;
      open_v <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < BLOCK_COUNT; i++) begin
        bcount[i] <= '0;
        page_valid[i] <= '0;
        ring[i] <= BW'(i % BLOCKS_PER_CHANNEL);
      end
      for (int c = 0; c < CHANNELS; c++) begin
        head[c] <= '0;
        tail[c] <= '0;
        fcount[c] <= (BW+1)'(BLOCKS_PER_CHANNEL);
        open_blk[c] <= '0;
        open_pg[c] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) gc_threshold <= cfg_data;
      unique case (state)
        S_IDLE: if (in_valid) begin
          cur_lba <= lba[LW-1:0];
          ch <= (kind == KIND_COLLECT) ? CW'(channel) : lba[CW-1:0];
          idx <= '0;
          found <= 1'b0;
          minv <= (PW+1)'(PAGES_PER_BLK);
          victim <= '0;
        end
        S_WR_RD: ;
        S_WR_OLD: if (map_mapped[cur_lba] && page_valid[{m_ch, m_blk}][m_pg]) begin
          page_valid[{m_ch, m_blk}][m_pg] <= 1'b0;
          if (bcount[{m_ch, m_blk}] != '0)
            bcount[{m_ch, m_blk}] <= bcount[{m_ch, m_blk}] - 1'b1;
        end
        S_RD_OUT: begin
          pend <= map_mapped[cur_lba] ?
            mk(ST_OK, cur_lba, m_ch, m_blk, m_pg, '0, '0, fcount[ch], gc_threshold, 1'b1) :
            mk(ST_UNMAPPED, cur_lba, ch, '0, '0, '0, '0, fcount[ch], gc_threshold, 1'b1);
          ret <= S_IDLE;
        end
        S_SCAN: begin
          if (!erased[scan_bi] && !(open_v[ch] && open_blk[ch] == idx)
              && bcount[scan_bi] < minv) begin
            minv <= bcount[scan_bi];
            victim <= idx;
            found <= 1'b1;
          end
          idx <= idx + 1'b1;
        end
        S_SCAN_LAST: begin
          pidx <= '0;
          if (!found) begin
            pend <= mk(ST_NO_VICTIM, '0, ch, '0, '0, '0, '0, fcount[ch], gc_threshold, 1'b1);
            ret <= S_IDLE;
          end
        end
        S_PG_RD: ;
        S_PG_CHK: if (!page_valid[vic_bi][pidx]) pidx <= pidx + 1'b1;
        default: ;
      endcase

      // write or relocation allocation
      if (state == S_WR_ALLOC || state == S_MOVE && out_free) begin
        if (can_alloc) begin
          if (need_open) begin
            head[ch] <= head[ch] + 1'b1;
            fcount[ch] <= fcount[ch] - 1'b1;
            open_v[ch] <= 1'b1;
            open_blk[ch] <= pop_blk;
          end
          open_pg[ch] <= need_open ? (PW+1)'(1) : open_pg[ch] + 1'b1;
          // a freshly opened block starts with only the new page valid
          page_valid[{ch, alloc_blk}] <= need_open ? alloc_bit
                                                   : page_valid[{ch, alloc_blk}] | alloc_bit;
          bcount[{ch, alloc_blk}] <= need_open ? (PW+1)'(1) : bcount[{ch, alloc_blk}] + 1'b1;
          erased[{ch, alloc_blk}] <= 1'b0;
          map_mapped[state == S_MOVE ? own_rdata : cur_lba] <= 1'b1;
        end
        if (state == S_WR_ALLOC) begin
          pend <= can_alloc ?
            mk(ST_OK, cur_lba, ch, alloc_blk, alloc_pg, '0, '0, fc_after, gc_threshold, 1'b1) :
            mk(ST_FULL, cur_lba, ch, '0, '0, '0, '0, fc_after, gc_threshold, 1'b1);
          ret <= S_IDLE;
        end else begin
          pend <= can_alloc ?
            mk(ST_MOVED, own_rdata, ch, alloc_blk, alloc_pg, victim, pidx, fc_after,
               gc_threshold, 1'b0) :
            mk(ST_LOST, own_rdata, ch, '0, '0, victim, pidx, fc_after, gc_threshold, 1'b0);
          ret <= (pidx == PW'(PAGES_PER_BLK-1)) ? S_ERASE : S_PG_RD;
          pidx <= pidx + 1'b1;
        end
      end

      if (state == S_ERASE) begin
        bcount[vic_bi] <= '0;
        erased[vic_bi] <= 1'b1;
        page_valid[vic_bi] <= '0;
        if (fcount[ch] < (BW+1)'(BLOCKS_PER_CHANNEL)) begin
          ring[{ch, tail[ch]}] <= victim;
          tail[ch] <= tail[ch] + 1'b1;
          fcount[ch] <= fcount[ch] + 1'b1;
        end
        pend <= mk(ST_DONE, '0, ch, victim, '0, '0, '0,
          (fcount[ch] < (BW+1)'(BLOCKS_PER_CHANNEL)) ? fcount[ch] + 1'b1 : fcount[ch],
          gc_threshold, 1'b1);
        ret <= S_IDLE;
      end

      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
        res <= pend;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status = res.status;
  assign item_lba = res.item_lba;
  assign out_channel = res.out_channel;
  assign block = res.block;
  assign page = res.page;
  assign from_block = res.from_block;
  assign from_page = res.from_page;
  assign free_blocks = res.free_blocks;
  assign needs_collect = res.needs_collect;
  assign last = res.last;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("accepted while busy");
  a_fcount_range: assert property (@(posedge clk) disable iff (rst)
    fcount[0] <= (BW+1)'(BLOCKS_PER_CHANNEL)) else $error("free count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res)) else $error("result lost");
endmodule
`default_nettype wire

// ===== hdl/pmf_ram.sv =====
`default_nettype none
module pmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== verif/tb_page_map_ftl_greedy_gc.sv =====
`timescale 1ns / 1ps
module tb_page_map_ftl_greedy_gc
  import pmf_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = '0;
  logic [4:0] lba = '0;
  logic channel = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [4:0] item_lba;
  logic out_channel;
  logic [2:0] block;
  logic [1:0] page;
  logic [2:0] from_block;
  logic [1:0] from_page;
  logic [3:0] free_blocks;
  logic needs_collect;
  logic last;

  page_map_ftl_greedy_gc uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .lba(lba), .channel(channel),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .item_lba(item_lba),
    .out_channel(out_channel), .block(block), .page(page), .from_block(from_block),
    .from_page(from_page), .free_blocks(free_blocks), .needs_collect(needs_collect),
    .last(last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // flash translation shadow state
  logic [3:0] thresh;
  logic mapped [LBA_COUNT];
  logic [CW-1:0] m_ch [LBA_COUNT];
  logic [BW-1:0] m_blk [LBA_COUNT];
  logic [PW-1:0] m_pg [LBA_COUNT];
  logic pv [TOTAL_PAGES];
  logic [LW-1:0] owner [TOTAL_PAGES];
  int vcount [BLOCK_COUNT];
  logic erased [BLOCK_COUNT];
  logic [BW-1:0] ring [BLOCK_COUNT];
  int head [CHANNELS], tail [CHANNELS], nfree [CHANNELS];
  logic op_valid [CHANNELS];
  int op_blk [CHANNELS], op_pg [CHANNELS];

  result_t pending_results[$];
  int errors = 0;
  int n_items = 0, n_words = 0;
  int idle_cycles = 0;

  function automatic int pidx(int c, int b, int p);
    return (c * BLOCKS_PER_CHANNEL + b) * PAGES_PER_BLK + p;
  endfunction

  function automatic void shadow_reset();
    thresh = 4'd2;
    for (int i = 0; i < LBA_COUNT; i++) begin
      mapped[i] = 1'b0; m_ch[i] = '0; m_blk[i] = '0; m_pg[i] = '0;
    end
    for (int i = 0; i < TOTAL_PAGES; i++) begin
      pv[i] = 1'b0; owner[i] = '0;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      for (int b = 0; b < BLOCKS_PER_CHANNEL; b++) begin
        vcount[c*BLOCKS_PER_CHANNEL+b] = 0;
        erased[c*BLOCKS_PER_CHANNEL+b] = 1'b1;
        ring[c*BLOCKS_PER_CHANNEL+b] = BW'(b);
      end
      head[c] = 0; tail[c] = 0; nfree[c] = BLOCKS_PER_CHANNEL;
      op_valid[c] = 1'b0; op_blk[c] = 0; op_pg[c] = 0;
    end
  endfunction

  function automatic void push_word(logic [2:0] st, int l, int c, int b, int p, int fb, int fp);
    result_t r;
    r.status = st; r.item_lba = 5'(l); r.out_channel = 1'(c); r.block = 3'(b);
    r.page = 2'(p); r.from_block = 3'(fb); r.from_page = 2'(fp);
    r.free_blocks = 4'(nfree[c]);
    r.needs_collect = (nfree[c] < int'(thresh)); r.last = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic bit alloc_page(int c, output int b, output int p);
    if (!op_valid[c] || op_pg[c] >= PAGES_PER_BLK) begin
      int nb;
      if (nfree[c] == 0) return 1'b0;
      nb = int'(ring[c*BLOCKS_PER_CHANNEL + head[c]]);
      head[c] = (head[c] + 1) % BLOCKS_PER_CHANNEL;
      nfree[c]--;
      op_valid[c] = 1'b1; op_blk[c] = nb; op_pg[c] = 0;
      erased[c*BLOCKS_PER_CHANNEL+nb] = 1'b0;
      vcount[c*BLOCKS_PER_CHANNEL+nb] = 0;
      for (int i = 0; i < PAGES_PER_BLK; i++) pv[pidx(c, nb, i)] = 1'b0;
    end
    b = op_blk[c]; p = op_pg[c]; op_pg[c]++;
    return 1'b1;
  endfunction

  function automatic void map_page(int c, int b, int p, int l);
    pv[pidx(c, b, p)] = 1'b1; owner[pidx(c, b, p)] = LW'(l);
    vcount[c*BLOCKS_PER_CHANNEL+b]++;
    erased[c*BLOCKS_PER_CHANNEL+b] = 1'b0;
    mapped[l] = 1'b1; m_ch[l] = CW'(c); m_blk[l] = BW'(b); m_pg[l] = PW'(p);
  endfunction

  // returns the number of words the item causes
  function automatic int predict_ftl(logic [1:0] k, logic [4:0] a, logic cc);
    int c, b, p, base, ai, oc, ob, op;
    base = pending_results.size();
    ai = int'(a);
    oc = int'(m_ch[ai]); ob = int'(m_blk[ai]); op = int'(m_pg[ai]);
    if (k == KIND_WRITE) begin
      c = ai % CHANNELS;
      if (mapped[ai] && pv[pidx(oc, ob, op)]) begin
        pv[pidx(oc, ob, op)] = 1'b0;
        if (vcount[oc*BLOCKS_PER_CHANNEL+ob] > 0)
          vcount[oc*BLOCKS_PER_CHANNEL+ob]--;
      end
      if (alloc_page(c, b, p)) begin
        map_page(c, b, p, ai);
        push_word(ST_OK, ai, c, b, p, 0, 0);
      end else push_word(ST_FULL, ai, c, 0, 0, 0, 0);
    end else if (k == KIND_READ) begin
      if (mapped[ai]) push_word(ST_OK, ai, oc, ob, op, 0, 0);
      else push_word(ST_UNMAPPED, ai, ai % CHANNELS, 0, 0, 0, 0);
    end else if (k == KIND_COLLECT) begin
      int victim, minv;
      bit found;
      c = int'(cc); victim = 0; minv = PAGES_PER_BLK; found = 1'b0;
      for (int i = 0; i < BLOCKS_PER_CHANNEL; i++) begin
        int bi;
        bi = c*BLOCKS_PER_CHANNEL + i;
        if (!erased[bi] && !(op_valid[c] && op_blk[c] == i) && vcount[bi] < minv) begin
          minv = vcount[bi]; victim = i; found = 1'b1;
        end
      end
      if (!found) push_word(ST_NO_VICTIM, 0, c, 0, 0, 0, 0);
      else begin
        for (int i = 0; i < PAGES_PER_BLK; i++) begin
          if (pv[pidx(c, victim, i)]) begin
            int o;
            o = int'(owner[pidx(c, victim, i)]);
            if (alloc_page(c, b, p)) begin
              map_page(c, b, p, o);
              push_word(ST_MOVED, o, c, b, p, victim, i);
            end else push_word(ST_LOST, o, c, 0, 0, victim, i);
          end
        end
        vcount[c*BLOCKS_PER_CHANNEL+victim] = 0;
        erased[c*BLOCKS_PER_CHANNEL+victim] = 1'b1;
        for (int i = 0; i < PAGES_PER_BLK; i++) pv[pidx(c, victim, i)] = 1'b0;
        if (nfree[c] < BLOCKS_PER_CHANNEL) begin
          ring[c*BLOCKS_PER_CHANNEL + tail[c]] = BW'(victim);
          tail[c] = (tail[c] + 1) % BLOCKS_PER_CHANNEL;
          nfree[c]++;
        end
        push_word(ST_DONE, 0, c, victim, 0, 0, 0);
      end
    end else return 0;
    pending_results[pending_results.size()-1].last = 1'b1;
    return pending_results.size() - base;
  endfunction

  // receiver: stall pattern, checking
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
    if (!rst && out_valid && !out_stall) begin
      result_t want;
      n_words++;
      if (pending_results.size() == 0) begin
        $error("unexpected word: status %0d lba %0d", status, item_lba);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d got %0d", want.status, status); errors++;
        end
        if (item_lba !== want.item_lba) begin
          $error("item_lba: expected %0d got %0d", want.item_lba, item_lba); errors++;
        end
        if (out_channel !== want.out_channel) begin
          $error("out_channel: expected %0d got %0d", want.out_channel, out_channel);
          errors++;
        end
        if (block !== want.block) begin
          $error("block: expected %0d got %0d", want.block, block); errors++;
        end
        if (page !== want.page) begin
          $error("page: expected %0d got %0d", want.page, page); errors++;
        end
        if (from_block !== want.from_block) begin
          $error("from_block: expected %0d got %0d", want.from_block, from_block); errors++;
        end
        if (from_page !== want.from_page) begin
          $error("from_page: expected %0d got %0d", want.from_page, from_page); errors++;
        end
        if (free_blocks !== want.free_blocks) begin
          $error("free_blocks: expected %0d got %0d", want.free_blocks, free_blocks);
          errors++;
        end
        if (needs_collect !== want.needs_collect) begin
          $error("needs_collect: expected %0d got %0d", want.needs_collect, needs_collect);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d got %0d", want.last, last); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moved
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d words outstanding", pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  typedef struct {
    logic [1:0] k;
    logic [4:0] a;
    logic c;
    bit typed;
    logic [2:0] st;
  } dir_row_t;

  dir_row_t dir_rows[$];
  int burst_left = 0;

  function automatic dir_row_t mk(logic [1:0] k, logic [4:0] a, logic c, bit t, logic [2:0] s);
    dir_row_t r;
    r.k = k; r.a = a; r.c = c; r.typed = t; r.st = s;
    return r;
  endfunction

  // valid stays high across a burst; it drops only for a gap or a stop_input call
  task automatic send_item(logic [1:0] k, logic [4:0] a, logic c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    kind <= k; lba <= a; channel <= c; in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    void'(predict_ftl(k, a, c));
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic drain_and_write(logic [3:0] val);
    stop_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1'b1; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    thresh = val;
  endtask

  // write-heavy with collects; small LBA windows cause overwrites and victims
  task automatic random_phase(int count);
    int win;
    win = $urandom_range(0, 1) ? 31 : $urandom_range(3, 12);
    for (int i = 0; i < count; i++) begin
      int r;
      logic [1:0] k;
      r = $urandom_range(0, 99);
      k = (r < 55) ? KIND_WRITE : (r < 75) ? KIND_READ : (r < 97) ? KIND_COLLECT : KIND_UNUSED;
      send_item(k, 5'($urandom_range(0, win)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    shadow_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir_rows.push_back(mk(KIND_READ, 5'd0, 1'b0, 1'b1, ST_UNMAPPED));
    dir_rows.push_back(mk(KIND_READ, 5'd31, 1'b1, 1'b1, ST_UNMAPPED));
    dir_rows.push_back(mk(KIND_COLLECT, 5'd0, 1'b0, 1'b1, ST_NO_VICTIM));
    dir_rows.push_back(mk(KIND_COLLECT, 5'd31, 1'b1, 1'b1, ST_NO_VICTIM));
    dir_rows.push_back(mk(KIND_UNUSED, 5'd31, 1'b1, 1'b0, ST_OK));
    dir_rows.push_back(mk(KIND_WRITE, 5'd0, 1'b0, 1'b1, ST_OK));
    dir_rows.push_back(mk(KIND_WRITE, 5'd31, 1'b1, 1'b1, ST_OK));
    dir_rows.push_back(mk(KIND_WRITE, 5'd0, 1'b1, 1'b1, ST_OK));
    dir_rows.push_back(mk(KIND_READ, 5'd0, 1'b0, 1'b0, ST_OK));
    for (int i = 0; i < 6; i++) dir_rows.push_back(mk(KIND_WRITE, 5'd2, 1'b0, 1'b0, ST_OK));
    dir_rows.push_back(mk(KIND_COLLECT, 5'd0, 1'b0, 1'b0, ST_OK));
    dir_rows.push_back(mk(KIND_COLLECT, 5'd0, 1'b0, 1'b0, ST_OK));
    dir_rows.push_back(mk(KIND_READ, 5'd2, 1'b0, 1'b0, ST_OK));
    dir_rows.push_back(mk(KIND_READ, 5'd31, 1'b0, 1'b0, ST_OK));

    foreach (dir_rows[i]) begin
      int before_n;
      before_n = pending_results.size();
      send_item(dir_rows[i].k, dir_rows[i].a, dir_rows[i].c);
      if (dir_rows[i].typed && pending_results.size() > before_n &&
          pending_results[pending_results.size()-1].status !== dir_rows[i].st) begin
        $error("directed row %0d: table status %0d, predicted %0d", i, dir_rows[i].st,
               pending_results[pending_results.size()-1].status);
        errors++;
      end
    end

    drain_and_write(4'd0);
    random_phase(50);
    drain_and_write(4'd8);
    // fill channel 1 far past capacity: full writes, lost moves, exhausted blocks
    for (int i = 0; i < 40; i++) send_item(KIND_WRITE, 5'((i % 16) * 2 + 1), 1'b0);
    for (int i = 0; i < 6; i++) send_item(KIND_COLLECT, 5'd0, 1'b1);
    drain_and_write(4'd15);
    random_phase(60);
    drain_and_write(4'd5);
    random_phase(60);

    stop_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("%0d items sent, %0d result words checked", n_items, n_words);
    $display("thresholds 2, 0, 8, 15 and 5 used; channel 1 driven past full");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/pmf_pkg.sv
hdl/pmf_ram.sv
hdl/page_map_ftl_greedy_gc.sv
verif/tb_page_map_ftl_greedy_gc.sv
